@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the RTL. Clock clk_i and reset rst_ni are assumed in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define DMCT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, off during reset.
`define DMCT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/core/dmct_pkg.sv @@
package dmct_pkg;

  // LINES must be a power of two: the line index is the low bits of the block number.
  localparam int unsigned LINES     = 256;
  localparam int unsigned ADDR_BITS = 48;
  localparam int unsigned IDX_BITS  = $clog2(LINES);
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned SHIFT_W   = 5;

  localparam logic [SHIFT_W-1:0] LINE_SHIFT_RST = SHIFT_W'(6);

  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_FLUSH = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    MISS_NONE     = 2'd0,
    MISS_COLD     = 2'd1,
    MISS_CONFLICT = 2'd2
  } miss_kind_e;

  // One transaction's effect on the statistics.
  typedef struct packed {
    logic access;
    logic hit;
    logic read_hit;
    logic write_hit;
    logic cold;
    logic conflict;
    logic wb;
  } stat_ev_t;

endpackage

@@ rtl/core/dmct_intf.sv @@
interface dmct_req_if
  import dmct_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [ADDR_BITS-1:0] address;
  logic [ADDR_BITS-1:0] block_number;

  modport source (output valid, mode, address, block_number, input ready);
  modport sink   (input valid, mode, address, block_number, output ready);
endinterface

interface dmct_rsp_if
  import dmct_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic                 flushed;
  logic [1:0]           miss_kind;
  logic                 writeback;
  logic [ADDR_BITS-1:0] victim_block;
  logic [CNT_W-1:0]     access_count;
  logic [CNT_W-1:0]     hit_count;
  logic [CNT_W-1:0]     read_hit_count;
  logic [CNT_W-1:0]     write_hit_count;
  logic [CNT_W-1:0]     cold_miss_count;
  logic [CNT_W-1:0]     conflict_miss_count;
  logic [CNT_W-1:0]     writeback_count;

  modport source (output valid, hit, flushed, miss_kind, writeback, victim_block,
                  access_count, hit_count, read_hit_count, write_hit_count,
                  cold_miss_count, conflict_miss_count, writeback_count,
                  input ready);
  modport sink   (input valid, hit, flushed, miss_kind, writeback, victim_block,
                  access_count, hit_count, read_hit_count, write_hit_count,
                  cold_miss_count, conflict_miss_count, writeback_count,
                  output ready);
endinterface

@@ rtl/core/direct_mapped_cache_tags.sv @@
// Pipeline: request -> lookup stage -> result register. Throughput: one transaction
// per cycle while results are taken; the tag RAM has one read and one write port,
// and a tag written by the previous transaction is forwarded to the next.
// Reset: valid and dirty bits and all counters clear at once, line_shift becomes 6;
// the tag RAM is not cleared (tags are only compared on valid lines).
`include "assert_macros.svh"

module direct_mapped_cache_tags
  import dmct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [SHIFT_W-1:0] cfg_data_i,
  dmct_req_if.sink           req,
  dmct_rsp_if.source         rsp
);

  logic [SHIFT_W-1:0] line_shift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_shift_q <= LINE_SHIFT_RST;
    end else if (cfg_we_i) begin
      line_shift_q <= cfg_data_i;
    end
  end

  // ---------------- request decode ----------------
  logic                 in_fire;
  logic [ADDR_BITS-1:0] s0_blk;
  logic [IDX_BITS-1:0]  s0_idx;
  mode_e                s0_mode;

  assign s0_mode = mode_e'(req.mode);
  assign s0_blk  = (s0_mode == MODE_FLUSH) ? req.block_number
                                           : (req.address >> line_shift_q);
  assign s0_idx  = s0_blk[IDX_BITS-1:0];
  assign in_fire = req.valid && req.ready;

  // ---------------- lookup stage ----------------
  logic                 s1_valid_q;
  mode_e                s1_mode_q;
  logic [ADDR_BITS-1:0] s1_blk_q;
  logic [IDX_BITS-1:0]  s1_idx_q;
  logic                 s1_byp_q;
  logic [ADDR_BITS-1:0] s1_byp_tag_q;
  logic                 s1_adv;
  logic                 s1_tag_we;

  logic [LINES-1:0]     valid_q, dirty_q;
  logic [ADDR_BITS-1:0] ram_rdata;
  logic [ADDR_BITS-1:0] s1_tag;
  logic                 s1_vld, s1_drt, s1_match;
  logic                 s1_acc, s1_hit, s1_miss, s1_flushed;
  stat_ev_t             s1_ev;

  logic                 out_valid_q;
  logic                 hit_q, flushed_q, wb_q;
  miss_kind_e           kind_q;
  logic [ADDR_BITS-1:0] victim_q;

  assign s1_adv    = s1_valid_q && (!out_valid_q || rsp.ready);
  assign req.ready = !s1_valid_q || s1_adv;

  assign s1_tag     = s1_byp_q ? s1_byp_tag_q : ram_rdata;
  assign s1_vld     = valid_q[s1_idx_q];
  assign s1_drt     = dirty_q[s1_idx_q];
  assign s1_match   = s1_vld && (s1_tag == s1_blk_q);
  assign s1_acc     = (s1_mode_q == MODE_READ) || (s1_mode_q == MODE_WRITE);
  assign s1_hit     = s1_acc && s1_match;
  assign s1_miss    = s1_acc && !s1_match;
  assign s1_flushed = (s1_mode_q == MODE_FLUSH) && s1_match;
  assign s1_tag_we  = s1_adv && s1_miss;

  always_comb begin
    s1_ev           = '0;
    s1_ev.access    = s1_acc;
    s1_ev.hit       = s1_hit;
    s1_ev.read_hit  = s1_hit && (s1_mode_q == MODE_READ);
    s1_ev.write_hit = s1_hit && (s1_mode_q == MODE_WRITE);
    s1_ev.cold      = s1_miss && !s1_vld;
    s1_ev.conflict  = s1_miss && s1_vld;
    s1_ev.wb        = s1_miss && s1_vld && s1_drt;
  end

  dmct_tag_ram u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (s1_tag_we),
    .waddr_i (s1_idx_q),
    .wdata_i (s1_blk_q),
    .re_i    (in_fire),
    .raddr_i (s0_idx),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Forward the tag being written this cycle when the new read hits the same line.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_mode_q    <= s0_mode;
      s1_blk_q     <= s0_blk;
      s1_idx_q     <= s0_idx;
      s1_byp_q     <= s1_tag_we && (s1_idx_q == s0_idx);
      s1_byp_tag_q <= s1_blk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
    end else if (s1_adv) begin
      if (s1_miss) begin
        valid_q[s1_idx_q] <= 1'b1;
        dirty_q[s1_idx_q] <= (s1_mode_q == MODE_WRITE);
      end else if (s1_ev.write_hit) begin
        dirty_q[s1_idx_q] <= 1'b1;
      end else if (s1_flushed) begin
        valid_q[s1_idx_q] <= 1'b0;
        dirty_q[s1_idx_q] <= 1'b0;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      hit_q     <= s1_hit;
      flushed_q <= s1_flushed;
      wb_q      <= s1_ev.wb;
      victim_q  <= s1_ev.conflict ? s1_tag : '0;
      if (s1_ev.cold) begin
        kind_q <= MISS_COLD;
      end else if (s1_ev.conflict) begin
        kind_q <= MISS_CONFLICT;
      end else begin
        kind_q <= MISS_NONE;
      end
    end
  end

  // Counters update on the same edge as the result register, so they read as
  // the post-transaction values while the result is held.
  dmct_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (s1_adv),
    .ev_i        (s1_ev),
    .access_o    (rsp.access_count),
    .hit_o       (rsp.hit_count),
    .read_hit_o  (rsp.read_hit_count),
    .write_hit_o (rsp.write_hit_count),
    .cold_o      (rsp.cold_miss_count),
    .conflict_o  (rsp.conflict_miss_count),
    .wb_o        (rsp.writeback_count)
  );

  assign rsp.valid        = out_valid_q;
  assign rsp.hit          = hit_q;
  assign rsp.flushed      = flushed_q;
  assign rsp.miss_kind    = kind_q;
  assign rsp.writeback    = wb_q;
  assign rsp.victim_block = victim_q;

  // ---------------- assertions ----------------
  `DMCT_ASSERT_IMP(a_wb_is_conflict, rsp.valid && rsp.writeback, rsp.miss_kind == MISS_CONFLICT)
  `DMCT_ASSERT_IMP(a_stall_blocks_input, s1_valid_q && !s1_adv, !req.ready)
  `DMCT_ASSERT_NXT(a_fill_sets_valid, s1_adv && s1_miss, valid_q[$past(s1_idx_q)])
  `DMCT_ASSERT_NXT(a_flush_clears, s1_adv && s1_flushed, !valid_q[$past(s1_idx_q)])

endmodule

@@ rtl/core/dmct_tag_ram.sv @@
module dmct_tag_ram
  import dmct_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [IDX_BITS-1:0]  waddr_i,
  input  logic [ADDR_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [IDX_BITS-1:0]  raddr_i,
  output logic [ADDR_BITS-1:0] rdata_o
);

  logic [ADDR_BITS-1:0] mem [LINES];
  logic [ADDR_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read returns the old contents on a same-address write; caller forwards.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dmct_stats.sv @@
module dmct_stats
  import dmct_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  stat_ev_t         ev_i,
  output logic [CNT_W-1:0] access_o,
  output logic [CNT_W-1:0] hit_o,
  output logic [CNT_W-1:0] read_hit_o,
  output logic [CNT_W-1:0] write_hit_o,
  output logic [CNT_W-1:0] cold_o,
  output logic [CNT_W-1:0] conflict_o,
  output logic [CNT_W-1:0] wb_o
);

  localparam int unsigned NCNT = 7;

  logic [CNT_W-1:0] cnt_q [NCNT];
  logic [CNT_W-1:0] cnt_d [NCNT];
  logic [NCNT-1:0]  inc;

  assign inc = {ev_i.wb, ev_i.conflict, ev_i.cold, ev_i.write_hit,
                ev_i.read_hit, ev_i.hit, ev_i.access};

  // Saturating increment per counter.
  always_comb begin
    for (int i = 0; i < NCNT; i++) begin
      cnt_d[i] = cnt_q[i];
      if (en_i && inc[i] && (cnt_q[i] != '1)) begin
        cnt_d[i] = cnt_q[i] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NCNT; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

  assign access_o    = cnt_q[0];
  assign hit_o       = cnt_q[1];
  assign read_hit_o  = cnt_q[2];
  assign write_hit_o = cnt_q[3];
  assign cold_o      = cnt_q[4];
  assign conflict_o  = cnt_q[5];
  assign wb_o        = cnt_q[6];

endmodule
